[hdl/wtsp_pkg.sv]
// ----------------------------------------------------------------------------
// wtsp_pkg: shared types and constants of the projection block
// Field widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package wtsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FX_W          = 32;
  localparam int DIM_W         = 14;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int QUO_W         = 31;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X_FIRST  = 3'd0,
    CFG_ROW_X_SECOND = 3'd1,
    CFG_ROW_Y_FIRST  = 3'd2,
    CFG_ROW_Y_SECOND = 3'd3,
    CFG_ROW_W_FIRST  = 3'd4,
    CFG_ROW_W_SECOND = 3'd5,
    CFG_SCREEN_W     = 3'd6,
    CFG_SCREEN_H     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic                 on_screen;
    logic signed [FX_W-1:0] screen_x;
    logic signed [FX_W-1:0] screen_y;
    logic signed [FX_W-1:0] depth_scale;
  } result_t;

  typedef struct packed {
    logic on_screen;
    logic neg_x;
    logic neg_y;
  } side_t;

endpackage

[hdl/wtsp_if.sv]
// ----------------------------------------------------------------------------
// wtsp_if: channel interfaces of the projection block
// Point input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface wtsp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface wtsp_result_if;
  logic               valid;
  logic               ready;
  logic               on_screen;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth_scale;
  modport source (output valid, on_screen, screen_x, screen_y, depth_scale, input ready);
  modport sink   (input valid, on_screen, screen_x, screen_y, depth_scale, output ready);
endinterface

interface wtsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/wtsp_dot.sv]
// ----------------------------------------------------------------------------
// wtsp_dot: one matrix row dot product
// Stage 1 multiplies, stage 2 floors, sums with translation and saturates.
// ----------------------------------------------------------------------------
module wtsp_dot #(
  parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [wtsp_pkg::FX_W-1:0]     px_i,
  input  logic signed [wtsp_pkg::FX_W-1:0]     py_i,
  input  logic signed [wtsp_pkg::FX_W-1:0]     pz_i,
  input  logic [wtsp_pkg::CFG_DATA_W-1:0]      row0_i,
  input  logic [wtsp_pkg::CFG_DATA_W-1:0]      row1_i,
  output logic signed [wtsp_pkg::FX_W-1:0]     dot_o
);
  import wtsp_pkg::*;

  localparam int SUM_W = 66 - FRAC_BITS;

  logic signed [63:0] p0_q, p1_q, p2_q;
  logic signed [FX_W-1:0] t_q;
  logic signed [FX_W-1:0] dot_q, dot_d;
  logic signed [SUM_W-1:0] sum;
  logic signed [63:0] s0, s1, s2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= 64'(px_i) * 64'($signed(row0_i[31:0]));
      p1_q <= 64'(py_i) * 64'($signed(row0_i[63:32]));
      p2_q <= 64'(pz_i) * 64'($signed(row1_i[31:0]));
      t_q  <= $signed(row1_i[63:32]);
    end
  end

  // Arithmetic shift floors toward minus infinity.
  assign s0  = p0_q >>> FRAC_BITS;
  assign s1  = p1_q >>> FRAC_BITS;
  assign s2  = p2_q >>> FRAC_BITS;
  assign sum = SUM_W'(s0) + SUM_W'(s1) + SUM_W'(s2) + SUM_W'(t_q);

  always_comb begin
    if (sum[SUM_W-1:FX_W-1] == '0 || sum[SUM_W-1:FX_W-1] == '1) begin
      dot_d = sum[FX_W-1:0];
    end else if (sum[SUM_W-1]) begin
      dot_d = 32'sh8000_0000;
    end else begin
      dot_d = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q <= dot_d;
    end
  end

  assign dot_o = dot_q;

endmodule

[hdl/wtsp_div.sv]
// ----------------------------------------------------------------------------
// wtsp_div: pipelined restoring divider
// One quotient bit per stage; flags a quotient that does not fit QUO_W bits.
// ----------------------------------------------------------------------------
module wtsp_div #(
  parameter int NUM_W = 65,
  parameter int DEN_W = 32,
  parameter int QUO_W = wtsp_pkg::QUO_W
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);
  import wtsp_pkg::*;

  localparam int HI_W  = NUM_W - QUO_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [DEN_W-1:0] rem_q [0:QUO_W];
  logic [QUO_W-1:0] low_q [0:QUO_W];
  logic [QUO_W-1:0] quo_q [0:QUO_W];
  logic [DEN_W-1:0] den_q [0:QUO_W];
  logic             ovf_q [0:QUO_W];

  logic [CMP_W-1:0] hi_ext, den_ext;

  assign hi_ext  = CMP_W'(num_i[NUM_W-1:QUO_W]);
  assign den_ext = CMP_W'(den_i);

  // Entry stage: range check on the high part, which seeds the remainder.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= (hi_ext >= den_ext);
      rem_q[0] <= hi_ext[DEN_W-1:0];
      low_q[0] <= num_i[QUO_W-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W:0] trial, diff;
    logic           ge;
    assign trial = {rem_q[k], low_q[k][QUO_W-1]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign ge    = !diff[DEN_W];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_q[k+1] <= {low_q[k][QUO_W-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][QUO_W-2:0], ge};
        den_q[k+1] <= den_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = quo_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];

endmodule

[hdl/world_to_screen_projection.sv]
// ----------------------------------------------------------------------------
// world_to_screen_projection: perspective projection and viewport mapping
// Projects Q16.16 world points to Q16.16 screen pixels, one point per cycle while the skid register is empty.
// ----------------------------------------------------------------------------
// The block takes one point per clock while the skid register is empty and
// gives one result per point, in order. Points pass through the matrix
// multiply and sum, the viewport numerators, the pipelined restoring dividers
// (one quotient bit per stage, 31 bits plus a range check stage) and one
// output register. A two-entry output (output register plus skid register)
// catches the beat that the sink refuses while the pipeline moves; while the
// skid register is full the whole pipeline and the input hold until it drains.
// Configuration writes are taken at once (ready is always high) and must
// only come while no point is in flight. There is no clearing pass.
module world_to_screen_projection #(
  parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wtsp_cfg_if.sink      cfg_i,
  wtsp_point_if.sink    point_i,
  wtsp_result_if.source result_o
);
  import wtsp_pkg::*;

  localparam int THR     = ((1 << FRAC_BITS) + 50) / 100;
  localparam int NUM_W   = 49 + FRAC_BITS;
  localparam int DIV_LAT = QUO_W + 1;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] row_q [0:5];
  logic [DIM_W-1:0]      wid_q, hgt_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) row_q[i] <= '0;
      wid_q <= WIDTH_RESET;
      hgt_q <= HEIGHT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ROW_X_FIRST:  row_q[0] <= cfg_i.data;
        CFG_ROW_X_SECOND: row_q[1] <= cfg_i.data;
        CFG_ROW_Y_FIRST:  row_q[2] <= cfg_i.data;
        CFG_ROW_Y_SECOND: row_q[3] <= cfg_i.data;
        CFG_ROW_W_FIRST:  row_q[4] <= cfg_i.data;
        CFG_ROW_W_SECOND: row_q[5] <= cfg_i.data;
        CFG_SCREEN_W:     wid_q    <= cfg_i.data[DIM_W-1:0];
        CFG_SCREEN_H:     hgt_q    <= cfg_i.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: hold everything while the skid register is occupied.
  logic    skid_full_q;
  logic    en;
  result_t skid_q;

  assign en            = !skid_full_q;
  assign point_i.ready = en;

  // Valid bits, one per stage.
  logic v1_q, v2_q, v3_q, v4_q, vout_q;
  logic vdiv_q [0:DIV_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      vout_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) vdiv_q[i] <= 1'b0;
    end else if (en) begin
      v1_q      <= point_i.valid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      vdiv_q[0] <= v4_q;
      for (int i = 1; i < DIV_LAT; i++) vdiv_q[i] <= vdiv_q[i-1];
      vout_q    <= vdiv_q[DIV_LAT-1];
    end
  end

  // Stages 1 and 2: the three row dot products.
  logic signed [FX_W-1:0] xv, yv, wv;

  wtsp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_x (
    .clk_i, .en_i(en), .px_i(point_i.point_x), .py_i(point_i.point_y),
    .pz_i(point_i.point_z), .row0_i(row_q[0]), .row1_i(row_q[1]), .dot_o(xv)
  );
  wtsp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_y (
    .clk_i, .en_i(en), .px_i(point_i.point_x), .py_i(point_i.point_y),
    .pz_i(point_i.point_z), .row0_i(row_q[2]), .row1_i(row_q[3]), .dot_o(yv)
  );
  wtsp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_w (
    .clk_i, .en_i(en), .px_i(point_i.point_x), .py_i(point_i.point_y),
    .pz_i(point_i.point_z), .row0_i(row_q[4]), .row1_i(row_q[5]), .dot_o(wv)
  );

  // Stage 3: W*(x+w) and H*(w-y), behind-viewer test.
  logic signed [FX_W:0]   xw, wy;
  logic signed [47:0]     prod_x_d, prod_y_d, prod_x_q, prod_y_q;
  logic signed [FX_W-1:0] wv3_q, wv4_q;
  logic                   on3_q;

  assign xw       = (FX_W+1)'(xv) + (FX_W+1)'(wv);
  assign wy       = (FX_W+1)'(wv) - (FX_W+1)'(yv);
  assign prod_x_d = 48'($signed({1'b0, wid_q})) * 48'(xw);
  assign prod_y_d = 48'($signed({1'b0, hgt_q})) * 48'(wy);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      wv3_q    <= wv;
      on3_q    <= (wv >= $signed(FX_W'(THR)));
    end
  end

  // Stage 4: add the rounding term, scale up and fold the sign so the
  // dividers see a non-negative dividend; floor(-m/d) = ~floor((m-1)/d).
  logic signed [48:0]      nx, ny;
  logic signed [NUM_W-1:0] nx_sh, ny_sh;
  logic [NUM_W-1:0]        mx_q, my_q;
  side_t                   sb4_q;
  side_t                   sb_q [0:DIV_LAT-1];

  assign nx    = 49'(prod_x_q) + 49'(wv3_q);
  assign ny    = 49'(prod_y_q) - 49'(wv3_q);
  assign nx_sh = {nx, {FRAC_BITS{1'b0}}};
  assign ny_sh = {ny, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q            <= nx[48] ? ~nx_sh : nx_sh;
      my_q            <= ny[48] ? ~ny_sh : ny_sh;
      wv4_q           <= wv3_q;
      sb4_q.on_screen <= on3_q;
      sb4_q.neg_x     <= nx[48];
      sb4_q.neg_y     <= ny[48];
    end
  end

  // Sideband travels alongside the dividers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb4_q;
      for (int i = 1; i < DIV_LAT; i++) sb_q[i] <= sb_q[i-1];
    end
  end

  // Dividers: x and y by 2w, depth by H. A zero H trips the range check.
  logic [QUO_W-1:0] qx, qy, qd;
  logic             ox, oy, od;
  logic [FX_W-1:0]  den_w;

  assign den_w = {wv4_q[FX_W-2:0], 1'b0};

  wtsp_div #(.NUM_W(NUM_W), .DEN_W(FX_W), .QUO_W(QUO_W)) u_div_x (
    .clk_i, .en_i(en), .num_i(mx_q), .den_i(den_w), .quo_o(qx), .ovf_o(ox)
  );
  wtsp_div #(.NUM_W(NUM_W), .DEN_W(FX_W), .QUO_W(QUO_W)) u_div_y (
    .clk_i, .en_i(en), .num_i(my_q), .den_i(den_w), .quo_o(qy), .ovf_o(oy)
  );
  wtsp_div #(.NUM_W(FX_W), .DEN_W(DIM_W), .QUO_W(QUO_W)) u_div_d (
    .clk_i, .en_i(en), .num_i(wv4_q), .den_i(hgt_q), .quo_o(qd), .ovf_o(od)
  );

  // Output stage: unfold sign, saturate, zero an off-screen result.
  side_t   sb_last;
  result_t res_d, ores_q;

  assign sb_last = sb_q[DIV_LAT-1];

  always_comb begin
    res_d = '0;
    if (sb_last.on_screen) begin
      res_d.on_screen = 1'b1;
      if (ox) begin
        res_d.screen_x = sb_last.neg_x ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        res_d.screen_x = sb_last.neg_x ? ~{1'b0, qx} : {1'b0, qx};
      end
      if (oy) begin
        res_d.screen_y = sb_last.neg_y ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        res_d.screen_y = sb_last.neg_y ? ~{1'b0, qy} : {1'b0, qy};
      end
      res_d.depth_scale = od ? 32'sh7FFF_FFFF : {1'b0, qd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ores_q <= res_d;
    end
  end

  // Skid register: catch the beat that the sink refuses while the pipe moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (en && vout_q && !result_o.ready) begin
      skid_full_q <= 1'b1;
    end else if (skid_full_q && result_o.ready) begin
      skid_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vout_q && !result_o.ready) begin
      skid_q <= ores_q;
    end
  end

  result_t out_sel;
  assign out_sel              = skid_full_q ? skid_q : ores_q;
  assign result_o.valid       = skid_full_q || vout_q;
  assign result_o.on_screen   = out_sel.on_screen;
  assign result_o.screen_x    = out_sel.screen_x;
  assign result_o.screen_y    = out_sel.screen_y;
  assign result_o.depth_scale = out_sel.depth_scale;

endmodule

[hdl/wtsp_checker.sv]
// ----------------------------------------------------------------------------
// wtsp_checker: port-level assertions for the projection block
// Checks output holding, off-screen results, input back-pressure and config ready.
// ----------------------------------------------------------------------------
module wtsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pt_ready_i,
  input logic        cfg_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        res_on_i,
  input logic [31:0] res_x_i,
  input logic [31:0] res_y_i,
  input logic [31:0] res_d_i
);

  // Hold a refused beat.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_x_i) &&
    $stable(res_y_i) && $stable(res_d_i) && $stable(res_on_i))
    else $error("result beat changed while stalled");

  // Drop the fields of a point behind the viewer.
  a_offscreen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_on_i |-> res_x_i == '0 && res_y_i == '0 && res_d_i == '0)
    else $error("off-screen result carries nonzero fields");

  // Back-pressure only while a result waits.
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pt_ready_i |-> res_valid_i)
    else $error("input stalled with no result pending");

  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pt_ready_i) |-> $past(res_valid_i && !res_ready_i))
    else $error("input stalled without a refused result");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel not ready");

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pt_ready_i  (point_i.ready),
  .cfg_ready_i (cfg_i.ready),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .res_on_i    (result_o.on_screen),
  .res_x_i     (result_o.screen_x),
  .res_y_i     (result_o.screen_y),
  .res_d_i     (result_o.depth_scale)
);

[test/world_to_screen_projection_tb.sv]
// ----------------------------------------------------------------------------
// world_to_screen_projection_tb: self-checking bench of the projection block
// Drives points and register writes, predicts each result in fixed point
// and compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module world_to_screen_projection_tb;
  import wtsp_pkg::*;

  localparam int  FB        = FRAC_BITS_DEF;
  localparam int  LATENCY   = 37;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk_i;
  logic rst_ni;

  wtsp_cfg_if    cfg_ch ();
  wtsp_point_if  pt_ch ();
  wtsp_result_if res_ch ();

  world_to_screen_projection u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_ch),
    .point_i  (pt_ch),
    .result_o (res_ch)
  );

  // Local copy of the register file.
  logic [63:0]      mat_q [6];
  logic [DIM_W-1:0] scr_w;
  logic [DIM_W-1:0] scr_h;

  result_t projected_q [$];
  int      error_count;
  int      result_count;
  int      offscreen_count;
  longint  cycle_count = 0;
  bit      gaps_on;
  bit      hold_sink;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[world_to_screen_projection] ERROR");
      $finish;
    end
  end

  function automatic longint sext(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Arithmetic shift right is a floor of the division by 2^FB.
  function automatic longint row_dot(input int base, input longint px, input longint py,
                                     input longint pz);
    longint s;
    s = (px * sext(mat_q[base][31:0])) >>> FB;
    s += (py * sext(mat_q[base][63:32])) >>> FB;
    s += (pz * sext(mat_q[base+1][31:0])) >>> FB;
    s += sext(mat_q[base+1][63:32]);
    return clamp32(s);
  endfunction

  // floor(n * 2^FB / d), saturated; d is positive.
  function automatic longint fx_quot(input longint n, input longint d);
    longint q, r, qlim;
    q = n / d;
    r = n % d;
    qlim = 64'sd1 <<< (31 - FB);
    if (r < 0) begin
      q -= 1;
      r += d;
    end
    if (q >= qlim) return 64'sd2147483647;
    if (q < -qlim) return -64'sd2147483648;
    return clamp32(q * (64'sd1 <<< FB) + (r * (64'sd1 <<< FB)) / d);
  endfunction

  function automatic result_t project_point(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] z);
    result_t r;
    longint xv, yv, wv, wid, hgt, thr;
    xv  = row_dot(0, sext(x), sext(y), sext(z));
    yv  = row_dot(2, sext(x), sext(y), sext(z));
    wv  = row_dot(4, sext(x), sext(y), sext(z));
    thr = ((64'sd1 <<< FB) + 50) / 100;
    wid = longint'(scr_w);
    hgt = longint'(scr_h);
    r   = '0;
    if (wv >= thr) begin
      r.on_screen   = 1'b1;
      r.screen_x    = 32'(fx_quot(wid * (xv + wv) + wv, 2 * wv));
      r.screen_y    = 32'(fx_quot(hgt * (wv - yv) - wv, 2 * wv));
      r.depth_scale = (hgt == 0) ? 32'h7FFF_FFFF : 32'(wv / hgt);
    end
    return r;
  endfunction

  // Result checker and sink-side backpressure.
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        res_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        res_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.on_screen, res_ch.screen_x, res_ch.screen_y, res_ch.depth_scale};
      if (projected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        error_count++;
      end else begin
        want = projected_q.pop_front();
        result_count++;
        if (!want.on_screen) offscreen_count++;
        if (got.on_screen !== want.on_screen) begin
          $display("%0t: on_screen exp %b act %b", $time, want.on_screen, got.on_screen);
          error_count++;
        end
        if (got.screen_x !== want.screen_x) begin
          $display("%0t: screen_x exp %h act %h", $time, want.screen_x, got.screen_x);
          error_count++;
        end
        if (got.screen_y !== want.screen_y) begin
          $display("%0t: screen_y exp %h act %h", $time, want.screen_y, got.screen_y);
          error_count++;
        end
        if (got.depth_scale !== want.depth_scale) begin
          $display("%0t: depth_scale exp %h act %h", $time, want.depth_scale,
                   got.depth_scale);
          error_count++;
        end
      end
    end
  end

  // Send one point; predict on acceptance.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      pt_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pt_ch.valid   <= 1'b1;
    pt_ch.point_x <= x;
    pt_ch.point_y <= y;
    pt_ch.point_z <= z;
    @(posedge clk_i);
    while (!pt_ch.ready) @(posedge clk_i);
    projected_q.push_back(project_point(x, y, z));
    @(negedge clk_i);
  endtask

  task automatic end_points();
    pt_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    end_points();
    while (projected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one register; only called while the pipeline is empty.
  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    if (idx < CFG_SCREEN_W) mat_q[idx] = value;
    else if (idx == CFG_SCREEN_W) scr_w = value[DIM_W-1:0];
    else scr_h = value[DIM_W-1:0];
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] fx_pair(input int lo, input int hi);
    return {32'(hi), 32'(lo)};
  endfunction

  // A camera-like matrix: identity-ish with w following z.
  task automatic load_camera(input int scale, input int w_off);
    write_reg(CFG_ROW_X_FIRST,  fx_pair(scale, 0));
    write_reg(CFG_ROW_X_SECOND, fx_pair(0, 0));
    write_reg(CFG_ROW_Y_FIRST,  fx_pair(0, scale));
    write_reg(CFG_ROW_Y_SECOND, fx_pair(0, 0));
    write_reg(CFG_ROW_W_FIRST,  fx_pair(0, 0));
    write_reg(CFG_ROW_W_SECOND, fx_pair(32'h0001_0000, w_off));
  endtask

  task automatic load_random_matrix();
    for (int i = 0; i < 6; i++) begin
      write_reg(cfg_idx_e'(i), {$urandom, $urandom});
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      2:       return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return 32'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0400_0000);
    endcase
  endfunction

  // Extremes of the fields, behind-viewer, threshold edge, zero height.
  task automatic test_directed();
    load_camera(32'h0001_0000, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_028F);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_028E);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0005_0000);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000);
    send_point(32'h0100_0000, 32'hFF00_0000, 32'h0000_1000);
    wait_drained();
    write_reg(CFG_SCREEN_W, 64'd8192);
    write_reg(CFG_SCREEN_H, 64'd0);
    send_point(32'h0003_0000, 32'h0001_8000, 32'h0002_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0300);
    wait_drained();
    write_reg(CFG_SCREEN_W, 64'd1);
    write_reg(CFG_SCREEN_H, 64'h3FFF);
    send_point(32'h0003_0000, 32'hFFFF_8000, 32'h0002_0000);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    wait_drained();
    write_reg(CFG_ROW_X_FIRST,  64'h8000_0000_7FFF_FFFF);
    write_reg(CFG_ROW_X_SECOND, 64'h7FFF_FFFF_8000_0000);
    write_reg(CFG_ROW_Y_FIRST,  64'h7FFF_FFFF_8000_0000);
    write_reg(CFG_ROW_Y_SECOND, 64'h8000_0000_7FFF_FFFF);
    write_reg(CFG_ROW_W_FIRST,  64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_ROW_W_SECOND, 64'h7FFF_FFFF_0000_0000);
    write_reg(CFG_SCREEN_W, 64'd8191);
    write_reg(CFG_SCREEN_H, 64'd8192);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    wait_drained();
  endtask

  // Random points under several camera and viewport settings.
  task automatic test_random(input int n_phases, input int per_phase);
    for (int p = 0; p < n_phases; p++) begin
      if ($urandom_range(0, 2) == 0) load_random_matrix();
      else load_camera($urandom_range(32'h0000_4000, 32'h0004_0000),
                       $urandom_range(0, 32'h0010_0000) - 32'h0002_0000);
      write_reg(CFG_SCREEN_W, $urandom_range(0, 3) == 0 ? 64'($urandom) :
                              64'($urandom_range(1, 8192)));
      write_reg(CFG_SCREEN_H, $urandom_range(0, 3) == 0 ? 64'($urandom) :
                              64'($urandom_range(1, 8192)));
      for (int i = 0; i < per_phase; i++) send_point(rand_coord(), rand_coord(), rand_coord());
      wait_drained();
    end
  endtask

  // Hold off the receiver long enough that the pipeline fills and stalls.
  task automatic test_backpressure();
    int hold_cycles;
    load_camera(32'h0001_0000, 32'h0001_0000);
    fork
      begin
        hold_sink = 1'b1;
        hold_cycles = 0;
        while (hold_cycles < 200) begin
          @(negedge clk_i);
          hold_cycles++;
        end
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 120; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    join
    wait_drained();
  endtask

  initial begin
    error_count     = 0;
    result_count    = 0;
    offscreen_count = 0;
    gaps_on         = 1'b1;
    hold_sink       = 1'b0;
    for (int i = 0; i < 6; i++) mat_q[i] = '0;
    scr_w = WIDTH_RESET;
    scr_h = HEIGHT_RESET;
    rst_ni        = 1'b0;
    pt_ch.valid   = 1'b0;
    pt_ch.point_x = '0;
    pt_ch.point_y = '0;
    pt_ch.point_z = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_ROW_X_FIRST;
    cfg_ch.data   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values: zero matrix gives w = 0, so everything is off-screen.
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    wait_drained();
    test_directed();
    test_random(10, 120);
    test_backpressure();
    // Last part: full rate on both sides.
    gaps_on = 1'b0;
    test_random(3, 100);
    end_points();
    while (projected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);

    $display("checked %0d results (%0d behind the viewer) over many matrix and viewport",
             result_count, offscreen_count);
    $display("settings, with random stalls, a long output hold and a full-rate tail");
    if (error_count == 0 && projected_q.size() == 0) begin
      $display("[world_to_screen_projection] OK");
    end else begin
      $display("[world_to_screen_projection] ERROR");
    end
    $finish;
  end
endmodule
